// ===== rtl/core/hkr_pkg.sv =====
// Shared constants and types for the HID boot keyboard report decoder.
`default_nettype none
package hkr_pkg;

  localparam int KeySlots        = 6;
  localparam int SlotFields      = 6;
  localparam int ModCount        = 8;
  localparam int NumCand         = ModCount + 2 * KeySlots;
  localparam int CandW           = $clog2(NumCand);
  localparam int SlotW           = (KeySlots > 1) ? $clog2(KeySlots) : 1;
  localparam int QueueDepth      = 2;
  localparam int QueuePtrW       = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int ModifierBase    = 224;
  localparam int MaxIgnoredUsage = 3;

  typedef enum logic [1:0] {
    EV_CONNECT    = 2'd0,
    EV_DISCONNECT = 2'd1,
    EV_REPORT     = 2'd2,
    EV_IGNORED    = 2'd3
  } event_kind_t;

  typedef logic [7:0] key_t;

  // One classified report: candidate mask ordered modifiers first, then per slot
  // release (even) and press (odd).
  typedef struct packed {
    logic [ModCount-1:0]       mods;
    logic [NumCand-1:0]        mask;
    key_t [KeySlots-1:0]       old_keys;
    key_t [KeySlots-1:0]       new_keys;
  } job_t;

endpackage
`default_nettype wire

// ===== rtl/core/hid_keyboard_report_to_key_events.sv =====
// Top level of the HID boot keyboard report decoder.
// Takes keyboard events (kind plus boot report) and turns each report into
// key items: modifier changes as usages 224 to 231, then per slot a release of
// the old key and a press of the new key where the other report lacks it. The
// last item of a report carries end_of_report; a report with no change gives
// one bare sync item. Failed transfers, non-report events and events while
// enabled is clear are taken and dropped. The front end classifies a report in
// the cycle it is taken, updates the stored report and queues a job (two deep);
// the back end loads a job and then issues one item per cycle into the output
// register while the output is free or being popped. Input is taken while the
// job queue has room, also while a result waits on the output.
`default_nettype none
module hid_keyboard_report_to_key_events (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic        cfg_wdata,
  input  wire logic        push,
  output logic             full,
  input  wire logic [1:0]  event_kind,
  input  wire logic        request_failed,
  input  wire logic [7:0]  modifier_bits,
  input  wire logic [7:0]  slot_key_0,
  input  wire logic [7:0]  slot_key_1,
  input  wire logic [7:0]  slot_key_2,
  input  wire logic [7:0]  slot_key_3,
  input  wire logic [7:0]  slot_key_4,
  input  wire logic [7:0]  slot_key_5,
  output logic             empty,
  input  wire logic        pop,
  output logic             key_event_valid,
  output logic [7:0]       usage_code,
  output logic             pressed,
  output logic             end_of_report
);

  hkr_pkg::key_t [hkr_pkg::SlotFields-1:0]  slot_field;
  hkr_pkg::key_t [hkr_pkg::KeySlots-1:0]    new_keys;
  hkr_pkg::job_t                            q_wr_data;
  hkr_pkg::job_t                            q_rd_data;
  logic                                     q_push;
  logic                                     q_pop;
  logic                                     q_empty;
  logic                                     accept;

  assign slot_field = {slot_key_5, slot_key_4, slot_key_3,
                       slot_key_2, slot_key_1, slot_key_0};

  // slots past the six report bytes read as no key
  always_comb begin
    for (int i = 0; i < hkr_pkg::KeySlots; i++) begin
      new_keys[i] = (i < hkr_pkg::SlotFields) ? slot_field[i] : '0;
    end
  end

  assign accept = push && !full;

  hkr_front u_front (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .accept         (accept),
    .event_kind     (hkr_pkg::event_kind_t'(event_kind)),
    .request_failed (request_failed),
    .modifier_bits  (modifier_bits),
    .new_keys       (new_keys),
    .q_push         (q_push),
    .q_data         (q_wr_data)
  );

  hkr_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (q_push),
    .wr_data (q_wr_data),
    .rd_en   (q_pop),
    .rd_data (q_rd_data),
    .full    (full),
    .empty   (q_empty)
  );

  hkr_back u_back (
    .clk             (clk),
    .rst             (rst),
    .q_data          (q_rd_data),
    .q_empty         (q_empty),
    .q_pop           (q_pop),
    .pop             (pop),
    .empty           (empty),
    .key_event_valid (key_event_valid),
    .usage_code      (usage_code),
    .pressed         (pressed),
    .end_of_report   (end_of_report)
  );

endmodule
`default_nettype wire

// ===== rtl/core/hkr_front.sv =====
// Front end: filters events, compares against the stored report, queues a job.
`default_nettype none
module hkr_front (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic                                   cfg_we,
  input  wire logic                                   cfg_wdata,
  input  wire logic                                   accept,
  input  wire hkr_pkg::event_kind_t                   event_kind,
  input  wire logic                                   request_failed,
  input  wire logic [hkr_pkg::ModCount-1:0]           modifier_bits,
  input  wire hkr_pkg::key_t [hkr_pkg::KeySlots-1:0]  new_keys,
  output logic                                        q_push,
  output hkr_pkg::job_t                               q_data
);

  logic                                      enabled;
  logic [hkr_pkg::ModCount-1:0]              prev_mods;
  hkr_pkg::key_t [hkr_pkg::KeySlots-1:0]     prev_keys;
  logic [hkr_pkg::NumCand-1:0]               mask;
  logic [hkr_pkg::KeySlots-1:0]              old_in_new;
  logic [hkr_pkg::KeySlots-1:0]              new_in_old;

  always_comb begin
    for (int i = 0; i < hkr_pkg::KeySlots; i++) begin
      old_in_new[i] = 1'b0;
      new_in_old[i] = 1'b0;
      for (int j = 0; j < hkr_pkg::KeySlots; j++) begin
        if (new_keys[j] == prev_keys[i]) old_in_new[i] = 1'b1;
        if (prev_keys[j] == new_keys[i]) new_in_old[i] = 1'b1;
      end
    end
    mask[hkr_pkg::ModCount-1:0] = modifier_bits ^ prev_mods;
    for (int i = 0; i < hkr_pkg::KeySlots; i++) begin
      mask[hkr_pkg::ModCount + 2*i] =
        (prev_keys[i] > hkr_pkg::key_t'(hkr_pkg::MaxIgnoredUsage)) && !old_in_new[i];
      mask[hkr_pkg::ModCount + 2*i + 1] =
        (new_keys[i] > hkr_pkg::key_t'(hkr_pkg::MaxIgnoredUsage)) && !new_in_old[i];
    end
  end

  assign q_push = accept && enabled && !request_failed &&
                  (event_kind == hkr_pkg::EV_REPORT);

  assign q_data = '{mods: modifier_bits, mask: mask, old_keys: prev_keys,
                    new_keys: new_keys};

  always_ff @(posedge clk) begin
    if (rst) begin
      enabled   <= 1'b0;
      prev_mods <= '0;
      prev_keys <= '0;
    end else begin
      if (cfg_we) enabled <= cfg_wdata;
      if (q_push) begin
        prev_mods <= modifier_bits;
        prev_keys <= new_keys;
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/hkr_queue.sv =====
// Short job queue between front and back end.
`default_nettype none
module hkr_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           wr_en,
  input  wire hkr_pkg::job_t  wr_data,
  input  wire logic           rd_en,
  output hkr_pkg::job_t       rd_data,
  output logic                full,
  output logic                empty
);

  localparam int PtrW = hkr_pkg::QueuePtrW;

  hkr_pkg::job_t     mem [hkr_pkg::QueueDepth];
  logic [PtrW-1:0]   wr_ptr;
  logic [PtrW-1:0]   rd_ptr;
  logic [PtrW:0]     count;

  assign full    = (count == (PtrW+1)'(hkr_pkg::QueueDepth));
  assign empty   = (count == '0);
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_ptr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == PtrW'(hkr_pkg::QueueDepth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == PtrW'(hkr_pkg::QueueDepth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (wr_en && !rd_en)      count <= count + 1'b1;
      else if (rd_en && !wr_en) count <= count - 1'b1;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/hkr_back.sv =====
// Back end: walks a job's candidate mask and emits one key item per cycle while the output is free or popped.
`default_nettype none
module hkr_back (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire hkr_pkg::job_t  q_data,
  input  wire logic           q_empty,
  output logic                q_pop,
  input  wire logic           pop,
  output logic                empty,
  output logic                key_event_valid,
  output logic [7:0]          usage_code,
  output logic                pressed,
  output logic                end_of_report
);

  localparam int CandW = hkr_pkg::CandW;
  localparam int SlotW = hkr_pkg::SlotW;

  hkr_pkg::job_t                job;
  logic [hkr_pkg::NumCand-1:0]  pending;
  logic [hkr_pkg::NumCand-1:0]  rest;
  logic                         busy;
  logic                         out_valid;
  logic                         can_emit;
  logic                         emit;
  logic [CandW-1:0]             pick;
  logic [CandW-1:0]             slot_off;
  logic [SlotW-1:0]             slot;
  hkr_pkg::key_t                pick_usage;
  logic                         pick_down;

  // lowest pending candidate goes first
  always_comb begin
    pick = '0;
    for (int i = hkr_pkg::NumCand - 1; i >= 0; i--) begin
      if (pending[i]) pick = CandW'(i);
    end
  end

  assign rest     = pending & (pending - 1'b1);
  assign slot_off = pick - CandW'(hkr_pkg::ModCount);
  assign slot     = slot_off[SlotW:1];

  always_comb begin
    if (pick < CandW'(hkr_pkg::ModCount)) begin
      pick_usage = hkr_pkg::key_t'(hkr_pkg::ModifierBase) + hkr_pkg::key_t'(pick[2:0]);
      pick_down  = job.mods[pick[2:0]];
    end else if (slot_off[0]) begin
      pick_usage = job.new_keys[slot];
      pick_down  = 1'b1;
    end else begin
      pick_usage = job.old_keys[slot];
      pick_down  = 1'b0;
    end
  end

  assign can_emit = !out_valid || pop;
  assign emit     = busy && can_emit;
  assign q_pop    = !busy && !q_empty;
  assign empty    = !out_valid;

  always_ff @(posedge clk) begin
    if (q_pop) job <= q_data;
    if (emit) begin
      if (pending == '0) begin
        key_event_valid <= 1'b0;
        usage_code      <= '0;
        pressed         <= 1'b0;
        end_of_report   <= 1'b1;
      end else begin
        key_event_valid <= 1'b1;
        usage_code      <= pick_usage;
        pressed         <= pick_down;
        end_of_report   <= (rest == '0);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      pending   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (emit)     out_valid <= 1'b1;
      else if (pop) out_valid <= 1'b0;
      if (q_pop) begin
        busy    <= 1'b1;
        pending <= q_data.mask;
      end else if (emit) begin
        pending <= rest;
        if (rest == '0) busy <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

// ===== tb/sv/key_event_check_pkg.sv =====
// Key-item predictor and checker class for the HID boot keyboard report decoder testbench.
package key_event_check_pkg;
  import hkr_pkg::*;

  typedef key_t [KeySlots-1:0] key_row_t;

  typedef struct packed {
    logic key_event_valid;
    key_t usage_code;
    logic pressed;
    logic end_of_report;
  } key_item_t;

  class key_change_tracker;
    bit          enabled;
    logic [7:0]  held_mods;
    key_row_t    held_keys;
    key_item_t   due_items[$];
    int unsigned mismatches;
    int unsigned taken;
    int unsigned decoded;
    int unsigned checked;

    function new();
      enabled    = 1'b0;
      held_mods  = '0;
      held_keys  = '0;
      mismatches = 0;
      taken      = 0;
      decoded    = 0;
      checked    = 0;
    endfunction

    function void set_enabled(bit value);
      enabled = value;
    endfunction

    function int unsigned pending();
      return due_items.size();
    endfunction

    function bit row_holds(key_row_t row, key_t usage);
      for (int i = 0; i < KeySlots; i++) begin
        if (row[i] == usage) return 1'b1;
      end
      return 1'b0;
    endfunction

    function void queue_change(key_t usage, logic down);
      key_item_t change;
      change.key_event_valid = 1'b1;
      change.usage_code      = usage;
      change.pressed         = down;
      change.end_of_report   = 1'b0;
      due_items.push_back(change);
    endfunction

    // Accepted event: work out the key items it should produce.
    function void take_event(event_kind_t kind, logic failed, logic [7:0] mods,
                             key_row_t keys);
      int unsigned first;
      logic [7:0]  flips;
      key_item_t   tail;
      taken++;
      if (failed || kind != EV_REPORT || !enabled) return;
      decoded++;
      first = due_items.size();
      flips = mods ^ held_mods;
      for (int i = 0; i < ModCount; i++) begin
        if (flips[i]) queue_change(8'(ModifierBase + i), mods[i]);
      end
      for (int s = 0; s < KeySlots; s++) begin
        if (held_keys[s] > MaxIgnoredUsage && !row_holds(keys, held_keys[s]))
          queue_change(held_keys[s], 1'b0);
        if (keys[s] > MaxIgnoredUsage && !row_holds(held_keys, keys[s]))
          queue_change(keys[s], 1'b1);
      end
      if (due_items.size() == first) begin
        tail = '{key_event_valid: 1'b0, usage_code: '0, pressed: 1'b0,
                 end_of_report: 1'b1};
      end else begin
        tail = due_items.pop_back();
        tail.end_of_report = 1'b1;
      end
      due_items.push_back(tail);
      held_mods = mods;
      held_keys = keys;
    endfunction

    function void compare_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        $error("%s mismatch: expected %0d, got %0d", name, want, got);
        mismatches++;
      end
    endfunction

    // Accepted key item: compare against the oldest one due.
    function void check_key_item(logic valid, logic [7:0] usage, logic down, logic eor);
      key_item_t want;
      checked++;
      if (due_items.size() == 0) begin
        $error("unexpected key item: valid %0d usage %0d down %0d end %0d",
               valid, usage, down, eor);
        mismatches++;
        return;
      end
      want = due_items.pop_front();
      compare_field("key_event_valid", 8'(want.key_event_valid), 8'(valid));
      compare_field("usage_code", want.usage_code, usage);
      compare_field("pressed", 8'(want.pressed), 8'(down));
      compare_field("end_of_report", 8'(want.end_of_report), 8'(eor));
    endfunction
  endclass

endpackage

// ===== tb/sv/tb.sv =====
// Self-checking testbench for the HID boot keyboard report decoder.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import hkr_pkg::*;
  import key_event_check_pkg::*;

  // Drain margin covers two queued jobs of up to 20 items each, plus the output register.
  localparam int DrainCycles = 64;
  localparam int HoldCycles  = 400;
  localparam int CycleLimit  = 300000;

  logic       clk            = 1'b0;
  logic       rst            = 1'b1;
  logic       cfg_we         = 1'b0;
  logic       cfg_wdata      = 1'b0;
  logic       push           = 1'b0;
  logic       full;
  logic [1:0] event_kind     = '0;
  logic       request_failed = 1'b0;
  logic [7:0] modifier_bits  = '0;
  logic [7:0] slot_key_0     = '0;
  logic [7:0] slot_key_1     = '0;
  logic [7:0] slot_key_2     = '0;
  logic [7:0] slot_key_3     = '0;
  logic [7:0] slot_key_4     = '0;
  logic [7:0] slot_key_5     = '0;
  logic       empty;
  logic       pop            = 1'b0;
  logic       key_event_valid;
  logic [7:0] usage_code;
  logic       pressed;
  logic       end_of_report;

  key_change_tracker tracker = new();

  int unsigned cycle_count = 0;
  int          burst_left  = 8;
  bit          hold_req    = 1'b0;
  bit          hold_done   = 1'b0;
  logic [7:0]  last_mods   = '0;
  key_row_t    last_keys   = '0;

  hid_keyboard_report_to_key_events u_top (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .push           (push),
    .full           (full),
    .event_kind     (event_kind),
    .request_failed (request_failed),
    .modifier_bits  (modifier_bits),
    .slot_key_0     (slot_key_0),
    .slot_key_1     (slot_key_1),
    .slot_key_2     (slot_key_2),
    .slot_key_3     (slot_key_3),
    .slot_key_4     (slot_key_4),
    .slot_key_5     (slot_key_5),
    .empty          (empty),
    .pop            (pop),
    .key_event_valid(key_event_valid),
    .usage_code     (usage_code),
    .pressed        (pressed),
    .end_of_report  (end_of_report)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic key_row_t slots(key_t a, key_t b, key_t c, key_t d, key_t e, key_t f);
    key_row_t row;
    row    = '0;
    row[0] = a;
    row[1] = b;
    row[2] = c;
    row[3] = d;
    row[4] = e;
    row[5] = f;
    return row;
  endfunction

  // Both handshakes are sampled at the edge, before the NBAs of this step land,
  // so the tracker sees exactly what the block saw.
  always @(posedge clk) begin
    if (!rst && push && !full)
      tracker.take_event(event_kind_t'(event_kind), request_failed, modifier_bits,
                         slots(slot_key_0, slot_key_1, slot_key_2,
                               slot_key_3, slot_key_4, slot_key_5));
    if (!rst && pop && !empty)
      tracker.check_key_item(key_event_valid, usage_code, pressed, end_of_report);
  end

  // Present one item and hold it until the block takes it. Push stays high on
  // return; pace() decides whether the burst goes on.
  task automatic offer(event_kind_t kind, logic failed, logic [7:0] mods, key_row_t keys);
    push           <= 1'b1;
    event_kind     <= kind;
    request_failed <= failed;
    modifier_bits  <= mods;
    slot_key_0     <= keys[0];
    slot_key_1     <= keys[1];
    slot_key_2     <= keys[2];
    slot_key_3     <= keys[3];
    slot_key_4     <= keys[4];
    slot_key_5     <= keys[5];
    @(posedge clk);
    while (full) @(posedge clk);
  endtask

  // Burst bookkeeping: at the end of a burst drop push for a random gap,
  // mostly short, sometimes long enough for the block to run dry.
  task automatic pace(bit stop);
    int gap;
    if (burst_left > 0) burst_left--;
    if (stop || burst_left == 0) begin
      push <= 1'b0;
      if (!stop) begin
        gap = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 4);
        repeat (gap) @(posedge clk);
        burst_left = $urandom_range(1, 16);
      end
    end
  endtask

  task automatic report(logic [7:0] mods, key_row_t keys);
    offer(EV_REPORT, 1'b0, mods, keys);
    pace(1'b0);
  endtask

  // Wait for every due key item, then let any dropped event work its way out.
  task automatic settle();
    @(posedge clk);
    while (tracker.pending() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_enabled(bit value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    tracker.set_enabled(value);
  endtask

  // One random item. Mostly reports that evolve from the previous one, so
  // keys stay held, move between slots, repeat or get released; some are fully
  // random reports and the rest is noise the block must drop. Only clean reports count towards the total.
  task automatic offer_random(output bit counted);
    key_row_t    keys;
    logic [7:0]  mods;
    int          pick;
    int          a;
    int          b;
    key_t        t;
    event_kind_t kind;
    pick = $urandom_range(0, 99);
    if (pick < 12) begin
      for (int i = 0; i < KeySlots; i++) keys[i] = 8'($urandom);
      case ($urandom_range(0, 3))
        0:       kind = EV_CONNECT;
        1:       kind = EV_DISCONNECT;
        2:       kind = EV_IGNORED;
        default: kind = EV_REPORT;
      endcase
      offer(kind, kind == EV_REPORT, 8'($urandom), keys);
      counted = 1'b0;
    end else begin
      if (pick < 20) begin
        mods = 8'($urandom);
        for (int i = 0; i < KeySlots; i++) keys[i] = 8'($urandom);
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 50)      mods = last_mods;
        else if (pick < 75) mods = last_mods ^ (8'd1 << $urandom_range(0, 7));
        else                mods = 8'($urandom);
        for (int i = 0; i < KeySlots; i++) begin
          pick = $urandom_range(0, 99);
          if (pick < 50)      keys[i] = last_keys[i];
          else if (pick < 75) keys[i] = 8'($urandom_range(4, 11));
          else if (pick < 85) keys[i] = 8'($urandom_range(0, 3));
          else if (pick < 93) keys[i] = '0;
          else                keys[i] = 8'($urandom);
        end
        if ($urandom_range(0, 4) == 0) begin
          a       = $urandom_range(0, KeySlots - 1);
          b       = $urandom_range(0, KeySlots - 1);
          t       = keys[a];
          keys[a] = keys[b];
          keys[b] = t;
        end
      end
      offer(EV_REPORT, 1'b0, mods, keys);
      last_mods = mods;
      last_keys = keys;
      counted   = 1'b1;
    end
  endtask

  // Receiver: segments of free-running, coin-flip and heavy stalling, plus
  // one long hold-off when asked, so the job queue backs up into full.
  initial begin
    int mode;
    int seg_left;
    mode     = 0;
    seg_left = 0;
    while (rst) @(posedge clk);
    forever begin
      if (hold_req && !hold_done) begin
        pop <= 1'b0;
        for (int k = 0; k < HoldCycles; k++) @(posedge clk);
        hold_done = 1'b1;
      end else begin
        if (seg_left == 0) begin
          mode     = $urandom_range(0, 2);
          seg_left = $urandom_range(20, 120);
        end
        seg_left--;
        case (mode)
          0:       pop <= 1'b1;
          1:       pop <= 1'($urandom_range(0, 1));
          default: pop <= ($urandom_range(0, 7) == 0);
        endcase
        @(posedge clk);
      end
    end
  end

  initial begin
    bit counted;
    int clean;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Straight out of reset decoding is off: this report must vanish.
    report(8'hFF, slots(8'd4, 8'd5, 8'd6, 8'd7, 8'd8, 8'd9));
    pace(1'b1);
    settle();
    write_enabled(1'b1);

    // Directed: extremes, every event kind, small usages, repeats, shuffles.
    report(8'h00, slots(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0));        // bare sync
    report(8'hFF, slots(8'd4, 8'd5, 8'd6, 8'd7, 8'd8, 8'd9));        // all presses
    report(8'h00, slots(8'd255, 8'd254, 8'd253, 8'd252, 8'd251, 8'd250)); // 20 items
    report(8'h00, slots(8'd255, 8'd254, 8'd253, 8'd252, 8'd251, 8'd250)); // unchanged
    offer(EV_REPORT, 1'b1, 8'h5A, slots(8'd4, 8'd4, 8'd4, 8'd4, 8'd4, 8'd4)); // failed
    pace(1'b0);
    offer(EV_CONNECT, 1'b0, 8'hFF, slots(8'd9, 8'd9, 8'd9, 8'd9, 8'd9, 8'd9));
    pace(1'b0);
    offer(EV_DISCONNECT, 1'b0, 8'hFF, slots(8'd9, 8'd9, 8'd9, 8'd9, 8'd9, 8'd9));
    pace(1'b0);
    offer(EV_IGNORED, 1'b0, 8'hFF, slots(8'd9, 8'd9, 8'd9, 8'd9, 8'd9, 8'd9));
    pace(1'b0);
    report(8'hA5, slots(8'd0, 8'd1, 8'd2, 8'd3, 8'd0, 8'd3));        // small usages
    report(8'hA5, slots(8'd4, 8'd4, 8'd4, 8'd9, 8'd9, 8'd3));        // repeated presses
    report(8'hA5, slots(8'd9, 8'd4, 8'd0, 8'd4, 8'd1, 8'd9));        // shuffled, no change
    report(8'h5A, slots(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0));        // repeated releases
    report(8'h80, slots(8'd224, 8'd225, 8'd226, 8'd227, 8'd228, 8'd229));
    report(8'h01, slots(8'd229, 8'd228, 8'd227, 8'd226, 8'd225, 8'd224));
    report(8'h00, slots(8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 8'd0));
    report(8'hFF, slots(8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255));
    report(8'h00, slots(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0));
    pace(1'b1);
    settle();

    // Random, decoding on; the receiver starts with its long hold-off.
    hold_req = 1'b1;
    clean    = 0;
    while (clean < 70) begin
      offer_random(counted);
      clean += counted;
      pace(1'b0);
    end
    pace(1'b1);
    settle();

    // Decoding off: everything is dropped and the stored report kept.
    write_enabled(1'b0);
    repeat (20) begin
      offer_random(counted);
      pace(1'b0);
    end
    pace(1'b1);
    settle();

    // Back on; the first report is compared against the one held before.
    write_enabled(1'b1);
    clean = 0;
    while (clean < 40) begin
      offer_random(counted);
      clean += counted;
      pace(1'b0);
    end
    pace(1'b1);
    settle();

    $display("Run covered %0d events, %0d decoded reports, %0d key items checked.",
             tracker.taken, tracker.decoded, tracker.checked);
    $display("Decoding toggled off and on; receiver held off for %0d cycles once.",
             HoldCycles);
    if (tracker.mismatches == 0 && tracker.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/hkr_pkg.sv
rtl/core/hkr_front.sv
rtl/core/hkr_queue.sv
rtl/core/hkr_back.sv
rtl/core/hid_keyboard_report_to_key_events.sv
tb/sv/key_event_check_pkg.sv
tb/sv/tb.sv
